>>> rtl/cnc_pkg.sv
package cnc_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned WIDE_WIDTH  = VALUE_WIDTH + 4;

  localparam logic [CHAR_WIDTH-1:0]  CHAR_NUL  = 8'h00;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO = 8'h30;
  localparam logic [CHAR_WIDTH-1:0]  CHAR_NINE = 8'h39;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

  // comparison phase codes
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [1:0] ORD_LESS  = 2'd0;
  localparam logic [1:0] ORD_EQUAL = 2'd1;
  localparam logic [1:0] ORD_MORE  = 2'd2;

  localparam logic [1:0] ST_VALID      = 2'd0;
  localparam logic [1:0] ST_BAD_FIRST  = 2'd1;
  localparam logic [1:0] ST_BAD_SECOND = 2'd2;

  typedef struct packed {
    logic start;
    logic step;
    logic clear;
  } lane_ctrl_t;

  typedef struct packed {
    logic [1:0]             phase;
    logic [1:0]             char_order;
    logic [VALUE_WIDTH-1:0] value_first;
    logic [VALUE_WIDTH-1:0] value_second;
    logic                   bad_first;
    logic                   bad_second;
  } snap_t;

  function automatic logic is_dec(input logic [CHAR_WIDTH-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

>>> rtl/cnc_in_if.sv
interface cnc_in_if;
  logic                            valid;
  logic                            ready;
  logic [cnc_pkg::CHAR_WIDTH-1:0]  char_first;
  logic [cnc_pkg::CHAR_WIDTH-1:0]  char_second;
  logic                            last_position;

  modport source (output valid, output char_first, output char_second,
                  output last_position, input ready);
  modport sink   (input valid, input char_first, input char_second,
                  input last_position, output ready);
endinterface

>>> rtl/cnc_out_if.sv
interface cnc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] order;
  logic [1:0] status;

  modport source (output valid, output order, output status, input ready);
  modport sink   (input valid, input order, input status, output ready);
endinterface

>>> rtl/cnc_lane.sv
module cnc_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cnc_pkg::lane_ctrl_t                 ctrl_i,
  input  logic [cnc_pkg::CHAR_WIDTH-1:0]      char_i,
  output logic [cnc_pkg::VALUE_WIDTH-1:0]     value_nx_o,
  output logic                                bad_nx_o
);

  logic [cnc_pkg::VALUE_WIDTH-1:0] value_q, value_d;
  logic                            ended_q, ended_d;
  logic                            bad_q, bad_d;
  logic [3:0]                      digit;
  logic [cnc_pkg::WIDE_WIDTH-1:0]  wide;
  logic [cnc_pkg::VALUE_WIDTH-1:0] acc;

  assign digit = 4'(char_i - cnc_pkg::CHAR_ZERO);

  // v*10 + d as two shifts and two adds, saturating
  always_comb begin
    wide = {1'b0, value_q, 3'b000} + {3'b000, value_q, 1'b0}
         + {(cnc_pkg::WIDE_WIDTH-4)'(0), digit};
    if (wide > {4'b0000, cnc_pkg::VALUE_MAX}) begin
      acc = cnc_pkg::VALUE_MAX;
    end else begin
      acc = wide[cnc_pkg::VALUE_WIDTH-1:0];
    end
  end

  always_comb begin
    value_d = value_q;
    ended_d = ended_q;
    bad_d   = bad_q;
    if (ctrl_i.start) begin
      value_d = {(cnc_pkg::VALUE_WIDTH-4)'(0), digit};
    end else if (ctrl_i.step && !ended_q) begin
      if (cnc_pkg::is_dec(char_i)) begin
        value_d = acc;
      end else begin
        ended_d = 1'b1;
        bad_d   = (char_i != cnc_pkg::CHAR_NUL);
      end
    end
  end

  assign value_nx_o = value_d;
  assign bad_nx_o   = bad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      ended_q <= 1'b0;
      bad_q   <= 1'b0;
    end else if (ctrl_i.clear) begin
      value_q <= '0;
      ended_q <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      value_q <= value_d;
      ended_q <= ended_d;
      bad_q   <= bad_d;
    end
  end

endmodule

>>> rtl/cnc_merge.sv
module cnc_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              snap_valid_i,
  input  cnc_pkg::snap_t    snap_i,
  output logic              snap_ready_o,
  cnc_out_if.source         out_o
);

  logic           s1_valid_q;
  cnc_pkg::snap_t s1_q;
  logic           out_valid_q;
  logic [1:0]     order_q, order_d;
  logic [1:0]     status_q, status_d;
  logic           out_go;

  assign out_go       = !out_valid_q || out_o.ready;
  assign snap_ready_o = !s1_valid_q || out_go;

  always_comb begin
    status_d = cnc_pkg::ST_VALID;
    order_d  = cnc_pkg::ORD_EQUAL;
    case (s1_q.phase)
      cnc_pkg::PH_DIGITS: begin
        if (s1_q.bad_first) begin
          status_d = cnc_pkg::ST_BAD_FIRST;
        end else if (s1_q.bad_second) begin
          status_d = cnc_pkg::ST_BAD_SECOND;
        end else if (s1_q.value_first < s1_q.value_second) begin
          order_d = cnc_pkg::ORD_LESS;
        end else if (s1_q.value_first > s1_q.value_second) begin
          order_d = cnc_pkg::ORD_MORE;
        end
      end
      cnc_pkg::PH_DONE: begin
        order_d = s1_q.char_order;
      end
      default: begin
        order_d = cnc_pkg::ORD_EQUAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (snap_ready_o) begin
        s1_valid_q <= snap_valid_i;
      end
      if (out_go) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      s1_q <= snap_i;
    end
    if (out_go && s1_valid_q) begin
      order_q  <= order_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.order  = order_q;
  assign out_o.status = status_q;

endmodule

>>> rtl/chromosome_name_compare.sv
// Natural-order compare of two names streamed one character pair per item.
// Throughput: one item per cycle unless out_o back-pressure fills both
// result registers, which drops in_i.ready. The result for the item that
// carries last_position goes to the snapshot register, then the output register.
// Reset (rst_ni, asynchronous, active low) clears phase, digit lanes and
// both pipeline valid flags; the block is ready as soon as reset is released.
module chromosome_name_compare (
  input  logic        clk_i,
  input  logic        rst_ni,
  cnc_in_if.sink      in_i,
  cnc_out_if.source   out_o
);

  logic [1:0]          phase_q, phase_d;
  logic [1:0]          char_order_q, char_order_d;
  logic                accept;
  logic                snap_ready;
  logic                both_dec;
  logic                same_nz;
  cnc_pkg::lane_ctrl_t lane_ctrl;
  cnc_pkg::snap_t      snap;
  logic [cnc_pkg::VALUE_WIDTH-1:0] value_first_nx, value_second_nx;
  logic                bad_first_nx, bad_second_nx;

  assign in_i.ready = snap_ready;
  assign accept     = in_i.valid && snap_ready;
  assign both_dec   = cnc_pkg::is_dec(in_i.char_first) && cnc_pkg::is_dec(in_i.char_second);
  assign same_nz    = (in_i.char_first == in_i.char_second)
                   && (in_i.char_first != cnc_pkg::CHAR_NUL);

  always_comb begin
    phase_d         = phase_q;
    char_order_d    = char_order_q;
    lane_ctrl.start = 1'b0;
    lane_ctrl.step  = 1'b0;
    lane_ctrl.clear = accept && in_i.last_position;
    if (accept) begin
      case (phase_q)
        cnc_pkg::PH_PREFIX: begin
          if (same_nz) begin
            phase_d = cnc_pkg::PH_PREFIX;
          end else if (!both_dec) begin
            phase_d = cnc_pkg::PH_DONE;
            if (in_i.char_first < in_i.char_second) begin
              char_order_d = cnc_pkg::ORD_LESS;
            end else if (in_i.char_first > in_i.char_second) begin
              char_order_d = cnc_pkg::ORD_MORE;
            end else begin
              char_order_d = cnc_pkg::ORD_EQUAL;
            end
          end else begin
            phase_d         = cnc_pkg::PH_DIGITS;
            lane_ctrl.start = 1'b1;
          end
        end
        cnc_pkg::PH_DIGITS: begin
          lane_ctrl.step = 1'b1;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  cnc_lane u_lane_first (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .char_i     (in_i.char_first),
    .value_nx_o (value_first_nx),
    .bad_nx_o   (bad_first_nx)
  );

  cnc_lane u_lane_second (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .char_i     (in_i.char_second),
    .value_nx_o (value_second_nx),
    .bad_nx_o   (bad_second_nx)
  );

  always_comb begin
    snap.phase        = phase_d;
    snap.char_order   = char_order_d;
    snap.value_first  = value_first_nx;
    snap.value_second = value_second_nx;
    snap.bad_first    = bad_first_nx;
    snap.bad_second   = bad_second_nx;
  end

  cnc_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (in_i.valid && in_i.last_position),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .out_o        (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cnc_pkg::PH_PREFIX;
      char_order_q <= cnc_pkg::ORD_EQUAL;
    end else if (accept && in_i.last_position) begin
      phase_q      <= cnc_pkg::PH_PREFIX;
      char_order_q <= cnc_pkg::ORD_EQUAL;
    end else begin
      phase_q      <= phase_d;
      char_order_q <= char_order_d;
    end
  end

endmodule
